### src/tick_counting_position_seeker_assert.svh
// assertion macros for the position seeker checker
`ifndef TICK_COUNTING_POSITION_SEEKER_ASSERT_SVH
`define TICK_COUNTING_POSITION_SEEKER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define TCPS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define TCPS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### src/tcps_pkg.sv
`timescale 1ns / 1ps

package tcps_pkg;

   typedef enum logic [2:0] {
      OP_SAMPLE      = 3'd0,
      OP_SET_TARGET  = 3'd1,
      OP_STOP        = 3'd2,
      OP_SEEK_BOTTOM = 3'd3,
      OP_SEEK_TOP    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_INITIAL_POSITION = 2'd0,
      CSR_UPPER_LIMIT      = 2'd1,
      CSR_LOWER_LIMIT      = 2'd2,
      CSR_STALL_SAMPLES    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_OFF  = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   localparam logic signed [15:0] UNSET_TARGET  = -16'sd1;
   localparam logic signed [15:0] BOTTOM_TARGET = 16'sh8000;
   localparam logic signed [15:0] TOP_TARGET    = 16'sd32766;
   localparam logic [7:0]         IDLE_MAX      = 8'd255;

   typedef struct packed {
      logic signed [15:0] position;
      logic signed [15:0] target;
      dir_type            drive;
      logic               sampling;
      logic               stalled;
   } result_type;

endpackage

### src/tick_counting_position_seeker.sv
`timescale 1ns / 1ps

// an accepted request beat is registered as its response beat, or parked in the skid register if the response is held
// throughput: one request beat per cycle while responses flow
// a held response admits one more beat into the skid register, then req_stall rises
// until the parked beat moves up into the response register
// reset (synchronous, active high) loads the csr defaults, position 0, target unset,
// motor off, sampler disarmed, and empties both output registers
module tick_counting_position_seeker
   import tcps_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic               req_sensor_level,
   input  logic signed [15:0] req_target_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_position,
   output logic signed [15:0] rsp_target,
   output logic [1:0]         rsp_drive,
   output logic               rsp_sampling,
   output logic               rsp_stalled,
   // csr write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   // compare width covers both the 16-bit target and the position counter
   localparam int CMP_BITS = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
   localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};

   // configuration registers; the initial position preset goes straight into the counter
   logic signed [15:0] upper_limit_ff;
   logic signed [15:0] lower_limit_ff;
   logic [7:0]         stall_samples_ff;

   // seeker state and its next value
   logic signed [POSITION_BITS-1:0] position_ff, position_in;
   logic signed [15:0]              target_ff, target_in;
   dir_type                         drive_ff, drive_in;
   dir_type                         coast_ff, coast_in;
   logic                            level_ff, level_in;
   logic signed [POSITION_BITS-1:0] last_position_ff, last_position_in;
   logic [7:0]                      idle_ff, idle_in;
   logic                            armed_ff, armed_in;
   logic                            stalled_in;

   // output register and skid register
   result_type out_ff, skid_ff, result_in;
   logic       out_valid_ff, skid_valid_ff;

   logic req_accept;
   logic out_free;
   logic csr_write;

   // a new beat is taken whenever the skid slot is empty
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   // the response register can load when empty or when its beat leaves now
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // ------------------------------------------------------------------
   // one request beat: command decode, sensor stepping, stall timeout
   // ------------------------------------------------------------------
   always_comb begin : seek_logic
      logic signed [15:0]       new_tgt;
      logic                     is_command;
      logic                     halt;
      logic signed [CMP_BITS-1:0] pos_c;
      logic signed [CMP_BITS-1:0] tgt_c;

      position_in      = position_ff;
      target_in        = target_ff;
      drive_in         = drive_ff;
      coast_in         = coast_ff;
      level_in         = level_ff;
      last_position_in = last_position_ff;
      idle_in          = idle_ff;
      armed_in         = armed_ff;
      stalled_in       = 1'b0;
      new_tgt          = UNSET_TARGET;
      is_command       = 1'b0;
      halt             = 1'b0;
      pos_c            = CMP_BITS'(position_ff);
      tgt_c            = CMP_BITS'(target_ff);

      unique case (op_type'(req_op))
         OP_SET_TARGET: begin
            new_tgt    = req_target_value;
            is_command = 1'b1;
         end
         OP_STOP: begin
            new_tgt    = UNSET_TARGET;
            is_command = 1'b1;
         end
         OP_SEEK_BOTTOM: begin
            new_tgt    = BOTTOM_TARGET;
            is_command = 1'b1;
         end
         OP_SEEK_TOP: begin
            new_tgt    = TOP_TARGET;
            is_command = 1'b1;
         end
         OP_SAMPLE: begin
            is_command = 1'b0;
         end
         default: begin
            // unused op codes leave the state alone
            is_command = 1'b0;
         end
      endcase

      if (is_command) begin
         // new target: start motion toward it, drop the drive when unset, keep it when it equals the position
         target_in = new_tgt;
         if (new_tgt == UNSET_TARGET) begin
            drive_in = DIR_OFF;
         end else if (CMP_BITS'(new_tgt) < pos_c) begin
            drive_in = DIR_DOWN;
            coast_in = DIR_DOWN;
            armed_in = 1'b1;
            idle_in  = '0;
         end else if (CMP_BITS'(new_tgt) > pos_c) begin
            drive_in = DIR_UP;
            coast_in = DIR_UP;
            armed_in = 1'b1;
            idle_in  = '0;
         end
      end else if (op_type'(req_op) == OP_SAMPLE && armed_ff) begin
         // a level change counts one step in the last driven direction
         if (req_sensor_level != level_ff) begin
            level_in = req_sensor_level;
            halt     = (target_ff != UNSET_TARGET);
            case (coast_ff)
               DIR_DOWN: begin
                  if (position_ff != POS_MIN) begin
                     position_in = position_ff - POSITION_BITS'(1);
                  end
                  halt = halt && (CMP_BITS'(position_in) <= tgt_c);
               end
               DIR_UP: begin
                  if (position_ff != POS_MAX) begin
                     position_in = position_ff + POSITION_BITS'(1);
                  end
                  halt = halt && (CMP_BITS'(position_in) >= tgt_c);
               end
               default: begin
                  halt = 1'b0;
               end
            endcase
            // target reached or passed
            if (halt) begin
               target_in = UNSET_TARGET;
               drive_in  = DIR_OFF;
            end
         end

         if (last_position_ff != position_in) begin
            idle_in = '0;
         end else begin
            if (idle_ff >= stall_samples_ff) begin
               // stall timeout: clamp, stop everything and disarm
               armed_in = 1'b0;
               if (CMP_BITS'(position_in) > CMP_BITS'(upper_limit_ff)) begin
                  position_in = POSITION_BITS'(upper_limit_ff);
               end else if (CMP_BITS'(position_in) < CMP_BITS'(lower_limit_ff)) begin
                  position_in = POSITION_BITS'(lower_limit_ff);
               end
               target_in  = UNSET_TARGET;
               drive_in   = DIR_OFF;
               coast_in   = DIR_OFF;
               stalled_in = 1'b1;
            end
            if (idle_ff < IDLE_MAX) begin
               idle_in = idle_ff + 8'd1;
            end
         end
         last_position_in = position_in;
      end

      result_in.position = 16'(position_in);
      result_in.target   = target_in;
      result_in.drive    = drive_in;
      result_in.sampling = armed_in;
      result_in.stalled  = stalled_in;
   end

   // ------------------------------------------------------------------
   // csr registers and seeker state
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_limit_ff      <= 16'sd32767;
         lower_limit_ff      <= '0;
         stall_samples_ff    <= 8'd8;
         position_ff         <= '0;
         target_ff           <= UNSET_TARGET;
         drive_ff            <= DIR_OFF;
         coast_ff            <= DIR_OFF;
         level_ff            <= 1'b0;
         last_position_ff    <= '0;
         idle_ff             <= '0;
         armed_ff            <= 1'b0;
      end else begin
         if (req_accept) begin
            position_ff      <= position_in;
            target_ff        <= target_in;
            drive_ff         <= drive_in;
            coast_ff         <= coast_in;
            level_ff         <= level_in;
            last_position_ff <= last_position_in;
            idle_ff          <= idle_in;
            armed_ff         <= armed_in;
         end
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_INITIAL_POSITION: begin
                  // preset loads the counter
                  position_ff <= POSITION_BITS'($signed(csr_data));
               end
               CSR_UPPER_LIMIT: begin
                  upper_limit_ff <= csr_data;
               end
               CSR_LOWER_LIMIT: begin
                  lower_limit_ff <= csr_data;
               end
               CSR_STALL_SAMPLES: begin
                  stall_samples_ff <= csr_data[7:0];
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // response register with skid slot
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // drain the parked beat first; no request is taken this cycle
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         // response held: park the new beat
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= result_in;
         end
      end else if (req_accept) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_position = out_ff.position;
   assign rsp_target   = out_ff.target;
   assign rsp_drive    = out_ff.drive;
   assign rsp_sampling = out_ff.sampling;
   assign rsp_stalled  = out_ff.stalled;

endmodule

### src/tcps_checker.sv
`timescale 1ns / 1ps
`include "tick_counting_position_seeker_assert.svh"

module tcps_checker
   import tcps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_position,
   input logic signed [15:0] rsp_target,
   input logic [1:0]         rsp_drive,
   input logic               rsp_sampling,
   input logic               rsp_stalled
);

   // a held response stays valid and keeps its position, target, drive and stalled flag
   `TCPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_position) && $stable(rsp_target) && $stable(rsp_drive) && $stable(rsp_stalled), "response changed while stalled")

   // the request side only stalls with a response already waiting
   `TCPS_ASSERT_NOW(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid, "request stalled with no response pending")

   // a running motor always has the sampler armed
   `TCPS_ASSERT_NOW(a_drive_armed, clock, reset, rsp_valid && (rsp_drive != DIR_OFF), rsp_sampling, "motor driven while sampler disarmed")

   // unset target means motor off
   `TCPS_ASSERT_NOW(a_unset_off, clock, reset, rsp_valid && (rsp_target == UNSET_TARGET), rsp_drive == DIR_OFF, "motor driven with no target")

   // a stall timeout leaves everything stopped
   `TCPS_ASSERT_NOW(a_stall_stop, clock, reset, rsp_valid && rsp_stalled, !rsp_sampling && (rsp_drive == DIR_OFF) && (rsp_target == UNSET_TARGET), "stall beat without full stop")

endmodule

bind tick_counting_position_seeker tcps_checker u_tcps_checker (.*);
